### hdl/t3dms_pkg.sv
// Shared package for the top-3 distinct-position maximum-sum block.
// Holds field widths, kept-entry and sum types and the bus data widths.
// Depends on nothing; every other file refers to it by scoped names.
package t3dms_pkg;

    localparam int VALUE_WIDTH    = 30;
    localparam int POSITION_WIDTH = 17;
    localparam int KEEP           = 3;
    localparam int NUM_COMB       = KEEP * KEEP * KEEP;
    localparam int SUM_WIDTH      = VALUE_WIDTH + 2;
    localparam int OUT_WIDTH      = 32;
    localparam int IN_DATA_WIDTH  = ((3 * VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((OUT_WIDTH + 7) / 8) * 8;
    localparam int L1_COUNT       = NUM_COMB / 3;
    localparam int L2_COUNT       = L1_COUNT / 3;

    // One kept slot: value and the position it came from
    typedef struct packed {
        logic [VALUE_WIDTH-1:0]    value;
        logic [POSITION_WIDTH-1:0] pos;
    } t_entry;

    // Three kept slots, index 0 holds the largest value
    typedef t_entry [KEEP-1:0] t_top3;

    typedef logic [SUM_WIDTH-1:0] t_sum;
    typedef t_sum [NUM_COMB-1:0]  t_sum_vec;

    // Largest sum that three kept values can reach
    localparam t_sum SUM_MAX =
        SUM_WIDTH'(3) * ((SUM_WIDTH'(1) << VALUE_WIDTH) - SUM_WIDTH'(1));

endpackage

### hdl/t3dms_rank.sv
// Top-3 keeper for one stream: compare-insert of each request, snapshot on the last one.
// Depends on t3dms_pkg for widths and the kept-entry types.
module t3dms_rank (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_last,
    input  logic [t3dms_pkg::VALUE_WIDTH-1:0]    i_value,
    input  logic [t3dms_pkg::POSITION_WIDTH-1:0] i_pos,
    output t3dms_pkg::t_top3                    o_fin
);

    t3dms_pkg::t_top3 r_top;
    t3dms_pkg::t_top3 n_top;
    t3dms_pkg::t_top3 r_fin;
    t3dms_pkg::t_entry w_new;

    // Insert the new value; strict compare keeps earlier positions ahead on ties
    always_comb begin
        w_new.value = i_value;
        w_new.pos   = i_pos;
        priority if (i_value > r_top[0].value) begin
            n_top = {r_top[1], r_top[0], w_new};
        end else if (i_value > r_top[1].value) begin
            n_top = {r_top[1], w_new, r_top[0]};
        end else if (i_value > r_top[2].value) begin
            n_top = {w_new, r_top[1], r_top[0]};
        end else begin
            n_top = r_top;
        end
    end

    // Advance the kept slots; drop them after the last request of a set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_en) begin
            r_top <= i_last ? '0 : n_top;
        end
    end

    // Hold the final slots of the set for the combination stage
    always_ff @(posedge i_clk) begin
        if (i_en && i_last) begin
            r_fin <= n_top;
        end
    end

    assign o_fin = r_fin;

endmodule

### hdl/t3dms_comb.sv
// Combination stage: all 27 picks of one slot per stream, registered as sums.
// A pick whose positions are not pairwise distinct registers as zero.
// Depends on t3dms_pkg for the kept-entry and sum types.
module t3dms_comb (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t3dms_pkg::t_top3      i_top_a,
    input  t3dms_pkg::t_top3      i_top_b,
    input  t3dms_pkg::t_top3      i_top_c,
    output t3dms_pkg::t_sum_vec   o_sum,
    output logic                  o_valid
);

    t3dms_pkg::t_sum_vec n_sum;
    t3dms_pkg::t_sum_vec r_sum;
    logic                r_valid;

    // Form each pick's sum and mask the ones with shared positions
    always_comb begin
        for (int i = 0; i < t3dms_pkg::KEEP; i++) begin
            for (int j = 0; j < t3dms_pkg::KEEP; j++) begin
                for (int k = 0; k < t3dms_pkg::KEEP; k++) begin
                    if ((i_top_a[i].pos != i_top_b[j].pos) &&
                        (i_top_a[i].pos != i_top_c[k].pos) &&
                        (i_top_b[j].pos != i_top_c[k].pos)) begin
                        n_sum[(i * t3dms_pkg::KEEP + j) * t3dms_pkg::KEEP + k] =
                            t3dms_pkg::SUM_WIDTH'(i_top_a[i].value) +
                            t3dms_pkg::SUM_WIDTH'(i_top_b[j].value) +
                            t3dms_pkg::SUM_WIDTH'(i_top_c[k].value);
                    end else begin
                        n_sum[(i * t3dms_pkg::KEEP + j) * t3dms_pkg::KEEP + k] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum   = r_sum;
    assign o_valid = r_valid;

endmodule

### hdl/t3dms_max.sv
// Registered maximum tree over the 27 pick sums: 27 to 9 to 3 to 1.
// The last level is the block's output register.
// Depends on t3dms_pkg for the sum types and tree sizes.
module t3dms_max (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t3dms_pkg::t_sum_vec  i_sum,
    output t3dms_pkg::t_sum      o_best,
    output logic                 o_valid
);

    t3dms_pkg::t_sum [t3dms_pkg::L1_COUNT-1:0] r_l1;
    t3dms_pkg::t_sum [t3dms_pkg::L2_COUNT-1:0] r_l2;
    t3dms_pkg::t_sum                            r_l3;
    logic r_v1;
    logic r_v2;
    logic r_v3;

    function automatic t3dms_pkg::t_sum max3(
        input t3dms_pkg::t_sum x,
        input t3dms_pkg::t_sum y,
        input t3dms_pkg::t_sum z
    );
        t3dms_pkg::t_sum m;
        m = (x > y) ? x : y;
        return (z > m) ? z : m;
    endfunction

    // Advance the valid flags with the tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Reduce by threes at each level
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < t3dms_pkg::L1_COUNT; n++) begin
                r_l1[n] <= max3(i_sum[3*n], i_sum[3*n+1], i_sum[3*n+2]);
            end
            for (int n = 0; n < t3dms_pkg::L2_COUNT; n++) begin
                r_l2[n] <= max3(r_l1[3*n], r_l1[3*n+1], r_l1[3*n+2]);
            end
            r_l3 <= max3(r_l2[0], r_l2[1], r_l2[2]);
        end
    end

    assign o_best  = r_l3;
    assign o_valid = r_v3;

endmodule

### hdl/top3_distinct_index_max_sum.sv
// Top-3 distinct-position maximum sum. Each request carries values of streams a, b and c at one
// position; the block takes one request per clock and keeps the three largest values of each
// stream with their positions (ties keep the earlier position). The request marked tlast closes
// the set: its result, the largest sum of one kept value per stream at three distinct positions
// (0 if none), reaches the master side through the input register, keeper snapshot, pick-sum
// register and maximum tree; the kept state is cleared for the next set. The rate is set by
// the compare-insert in each stream keeper; the 27 pick sums and the three-level maximum tree
// are pipelined behind it. A stalled result stalls the whole pipeline and drops tready.
// Depends on t3dms_pkg, t3dms_rank, t3dms_comb and t3dms_max.
module top3_distinct_index_max_sum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // value_a [29:0], value_b [59:30], value_c [89:60], zero fill above
    input  logic [t3dms_pkg::IN_DATA_WIDTH-1:0]  i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // best_sum [31:0]
    output logic [t3dms_pkg::OUT_DATA_WIDTH-1:0] o_m_axis_tdata
);

    localparam int VW = t3dms_pkg::VALUE_WIDTH;

    logic                                 w_en;
    logic                                 w_rank_en;
    logic                                 r_v0;
    logic                                 r_last;
    logic [VW-1:0]                        r_a;
    logic [VW-1:0]                        r_b;
    logic [VW-1:0]                        r_c;
    logic [t3dms_pkg::POSITION_WIDTH-1:0] r_pos;
    logic                                 r_fin_v;
    t3dms_pkg::t_top3                     w_fin_a;
    t3dms_pkg::t_top3                     w_fin_b;
    t3dms_pkg::t_top3                     w_fin_c;
    t3dms_pkg::t_sum_vec                  w_sum;
    logic                                 w_sum_v;
    t3dms_pkg::t_sum                      w_best;
    logic                                 w_best_v;

    // Whole pipeline moves unless a result waits on a stalled master side
    assign w_en            = !w_best_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_rank_en       = w_en && r_v0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a    <= i_s_axis_tdata[VW-1:0];
            r_b    <= i_s_axis_tdata[2*VW-1:VW];
            r_c    <= i_s_axis_tdata[3*VW-1:2*VW];
            r_last <= i_s_axis_tlast;
        end
    end

    // Position counter wraps naturally; restart at zero after the last request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fin_v <= 1'b0;
        end else if (w_en) begin
            r_fin_v <= r_v0 && r_last;
            if (r_v0) begin
                r_pos <= r_last ? '0 : r_pos + 1'b1;
            end
        end
    end

    t3dms_rank u_rank_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_rank_en),
        .i_last  (r_last),
        .i_value (r_a),
        .i_pos   (r_pos),
        .o_fin   (w_fin_a)
    );

    t3dms_rank u_rank_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_rank_en),
        .i_last  (r_last),
        .i_value (r_b),
        .i_pos   (r_pos),
        .o_fin   (w_fin_b)
    );

    t3dms_rank u_rank_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_rank_en),
        .i_last  (r_last),
        .i_value (r_c),
        .i_pos   (r_pos),
        .o_fin   (w_fin_c)
    );

    t3dms_comb u_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_fin_v),
        .i_top_a (w_fin_a),
        .i_top_b (w_fin_b),
        .i_top_c (w_fin_c),
        .o_sum   (w_sum),
        .o_valid (w_sum_v)
    );

    t3dms_max u_max (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_v),
        .i_sum   (w_sum),
        .o_best  (w_best),
        .o_valid (w_best_v)
    );

    assign o_m_axis_tvalid = w_best_v;
    assign o_m_axis_tdata  = t3dms_pkg::OUT_DATA_WIDTH'(t3dms_pkg::OUT_WIDTH'(w_best));

endmodule

### hdl/t3dms_chk.sv
// Port-level checker for the top-3 distinct-position maximum-sum block, bound to the top level.
// Depends on t3dms_pkg for widths and the largest reachable sum.
module t3dms_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic [t3dms_pkg::IN_DATA_WIDTH-1:0]  i_s_axis_tdata,
    input logic                                i_s_axis_tlast,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [t3dms_pkg::OUT_DATA_WIDTH-1:0] o_m_axis_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("request taken while result stalled");

    // An empty output side always takes requests
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("ready low with no result pending");

    // A result never exceeds three full-scale values
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> 64'(o_m_axis_tdata) <= 64'(t3dms_pkg::SUM_MAX))
        else $error("result out of range");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind top3_distinct_index_max_sum t3dms_chk u_chk (.*);
